// ===== rtl/tdia_pkg.sv =====
`timescale 1ns / 1ps

package tdia_pkg;

    localparam int TRACK_W  = 8;
    localparam int TUPLE_W  = 4 * TRACK_W;
    localparam int ID_W     = 7;
    localparam int COUNT_W  = 8;
    localparam logic [COUNT_W-1:0] ID_SPACE = 8'd128;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

    // One table entry: the stored tuple and the id it was given.
    typedef struct packed {
        logic [TUPLE_W-1:0] tuple;
        logic [ID_W-1:0]    id;
    } t_entry;

endpackage

// ===== rtl/tdia_ctrl.sv =====
`timescale 1ns / 1ps

module tdia_ctrl
    import tdia_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_DONE: begin
                o_cmd.finish = i_status.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ===== rtl/tdia_datapath.sv =====
`timescale 1ns / 1ps

module tdia_datapath
    import tdia_pkg::*;
#(
    parameter int MAX_POSITIONS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_start_sequence,
    input  logic               i_last_position,
    input  logic [TRACK_W-1:0] i_track_voice0,
    input  logic [TRACK_W-1:0] i_track_voice1,
    input  logic [TRACK_W-1:0] i_track_voice2,
    input  logic [TRACK_W-1:0] i_track_voice3,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ID_W-1:0]    o_pattern_number,
    output logic               o_is_new,
    output logic [COUNT_W-1:0] o_pattern_count,
    output logic               o_overflow,
    output logic               o_final_result
);

    localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int CW = $clog2(MAX_POSITIONS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_POSITIONS);

    t_entry r_mem [MAX_POSITIONS];

    logic [TUPLE_W-1:0] r_tuple;
    logic               r_last;
    logic [CW-1:0]      r_stored;
    logic [COUNT_W-1:0] r_distinct;
    logic [CW-1:0]      r_issue;
    t_entry             r_q;
    logic               r_q_vld;
    logic               r_found;
    logic [ID_W-1:0]    r_match_id;

    logic               r_out_vld;
    logic [ID_W-1:0]    r_out_id;
    logic               r_out_new;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_over;
    logic               r_out_last;

    logic               issue_en;
    logic               full;
    logic               new_ok;
    logic               over;
    logic [ID_W-1:0]    res_id;
    logic [COUNT_W-1:0] n_distinct;

    assign issue_en = i_cmd.scan && !r_found && (r_issue < r_stored);

    assign o_status.scan_done = r_found || ((r_issue >= r_stored) && !r_q_vld);
    assign o_status.out_free  = !r_out_vld || !i_out_stall;

    // Result of the finished scan, used when the word is handed to the output.
    assign full       = (r_stored >= FULL_CNT);
    assign new_ok     = !r_found && !full && (r_distinct < ID_SPACE);
    assign over       = r_found ? full : !new_ok;
    assign n_distinct = new_ok ? (r_distinct + COUNT_W'(1)) : r_distinct;

    always_comb begin
        if (r_found) begin
            res_id = r_match_id;
        end else if (new_ok) begin
            res_id = r_distinct[ID_W-1:0];
        end else begin
            res_id = '0;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && !over) begin
            r_mem[r_stored[AW-1:0]] <= '{tuple: r_tuple, id: res_id};
        end
        if (issue_en) begin
            r_q <= r_mem[r_issue[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tuple <= {i_track_voice0, i_track_voice1, i_track_voice2, i_track_voice3};
            r_last  <= i_last_position;
        end
        if (r_q_vld && !r_found && (r_q.tuple == r_tuple)) begin
            r_match_id <= r_q.id;
        end
        if (i_cmd.finish) begin
            r_out_id    <= res_id;
            r_out_new   <= new_ok;
            r_out_count <= n_distinct;
            r_out_over  <= over;
            r_out_last  <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored   <= '0;
            r_distinct <= '0;
            r_issue    <= '0;
            r_q_vld    <= 1'b0;
            r_found    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_issue <= '0;
                r_q_vld <= 1'b0;
                r_found <= 1'b0;
                if (i_start_sequence) begin
                    r_stored   <= '0;
                    r_distinct <= '0;
                end
            end else begin
                r_q_vld <= issue_en;
                if (issue_en) begin
                    r_issue <= r_issue + CW'(1);
                end
                if (r_q_vld && !r_found && (r_q.tuple == r_tuple)) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_distinct <= n_distinct;
                if (!over) begin
                    r_stored <= r_stored + CW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_pattern_number = r_out_id;
    assign o_is_new         = r_out_new;
    assign o_pattern_count  = r_out_count;
    assign o_overflow       = r_out_over;
    assign o_final_result   = r_out_last;

endmodule

// ===== rtl/tuple_dedup_id_assigner_top.sv =====
`timescale 1ns / 1ps

// Assigns dense pattern numbers to positions, each a tuple of four 8-bit track
// numbers. Every accepted word is compared, oldest first, with the positions
// stored since the last start flag; the first match returns that position's
// pattern number, otherwise the next free number is given and the distinct
// count rises. A word with start_sequence set empties the table before it is
// handled. Positions beyond MAX_POSITIONS (or a new tuple once 128 patterns
// exist) are not stored and set overflow. One word is handled at a time. The
// table scan reads one stored entry per cycle through the single read port
// of the table memory, and it stops early when a match is found. The result
// sits in an output register, so the block finishes its next scan while a
// result is still waiting to be taken. The table needs no clearing pass
// after reset.

module tuple_dedup_id_assigner_top
    import tdia_pkg::*;
#(
    parameter int MAX_POSITIONS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_start_sequence,
    input  logic               i_last_position,
    input  logic [TRACK_W-1:0] i_track_voice0,
    input  logic [TRACK_W-1:0] i_track_voice1,
    input  logic [TRACK_W-1:0] i_track_voice2,
    input  logic [TRACK_W-1:0] i_track_voice3,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ID_W-1:0]    o_pattern_number,
    output logic               o_is_new,
    output logic [COUNT_W-1:0] o_pattern_count,
    output logic               o_overflow,
    output logic               o_final_result
);

    t_cmd    cmd;
    t_status status;

    // The controller sequences accept, scan and hand-off of each word.
    tdia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the table, the counters and the output register.
    tdia_datapath #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_start_sequence (i_start_sequence),
        .i_last_position  (i_last_position),
        .i_track_voice0   (i_track_voice0),
        .i_track_voice1   (i_track_voice1),
        .i_track_voice2   (i_track_voice2),
        .i_track_voice3   (i_track_voice3),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pattern_number (o_pattern_number),
        .o_is_new         (o_is_new),
        .o_pattern_count  (o_pattern_count),
        .o_overflow       (o_overflow),
        .o_final_result   (o_final_result)
    );

endmodule

// ===== test/tdia_checker.sv =====
`timescale 1ns / 1ps

module tdia_checker
    import tdia_pkg::*;
#(
    parameter int MAX_POSITIONS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_start_sequence,
    input  logic               i_last_position,
    input  logic [TRACK_W-1:0] i_track_voice0,
    input  logic [TRACK_W-1:0] i_track_voice1,
    input  logic [TRACK_W-1:0] i_track_voice2,
    input  logic [TRACK_W-1:0] i_track_voice3,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [ID_W-1:0]    i_pattern_number,
    input  logic               i_is_new,
    input  logic [COUNT_W-1:0] i_pattern_count,
    input  logic               i_overflow,
    input  logic               i_final_result,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               is_new;
        logic [COUNT_W-1:0] count;
        logic               overflow;
        logic               final_res;
    } t_pattern_result;

    // Shadow copy of the table, valid below stored_cnt only.
    logic [TUPLE_W-1:0] seen_tuple [MAX_POSITIONS];
    logic [ID_W-1:0]    seen_id    [MAX_POSITIONS];
    int                 stored_cnt;
    int                 distinct_cnt;

    t_pattern_result    expected_ids [$];
    int                 mismatch_cnt;

    function automatic t_pattern_result assign_pattern_id(
        input logic               start,
        input logic               last,
        input logic [TUPLE_W-1:0] tuple
    );
        t_pattern_result r;
        bit              found;
        r     = '0;
        found = 1'b0;
        if (start) begin
            stored_cnt   = 0;
            distinct_cnt = 0;
        end
        // Oldest match wins.
        for (int i = 0; i < stored_cnt; i++) begin
            if (!found && seen_tuple[i] == tuple) begin
                r.id  = seen_id[i];
                found = 1'b1;
            end
        end
        if (!found) begin
            if (stored_cnt < MAX_POSITIONS && distinct_cnt < int'(ID_SPACE)) begin
                r.id   = distinct_cnt[ID_W-1:0];
                r.is_new = 1'b1;
                distinct_cnt++;
            end else begin
                r.overflow = 1'b1;
            end
        end else if (stored_cnt >= MAX_POSITIONS) begin
            r.overflow = 1'b1;
        end
        if (!r.overflow && stored_cnt < MAX_POSITIONS) begin
            seen_tuple[stored_cnt] = tuple;
            seen_id[stored_cnt]    = r.id;
            stored_cnt++;
        end
        r.count     = distinct_cnt[COUNT_W-1:0];
        r.final_res = last;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pattern_result want;
        t_pattern_result got;
        if (!i_rst_n) begin
            stored_cnt   = 0;
            distinct_cnt = 0;
            mismatch_cnt = 0;
            expected_ids.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_ids.push_back(assign_pattern_id(i_start_sequence, i_last_position,
                    {i_track_voice0, i_track_voice1, i_track_voice2, i_track_voice3}));
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_pattern_number, i_is_new, i_pattern_count, i_overflow,
                       i_final_result};
                if (expected_ids.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $write("%0t: result word with none expected: ", $realtime);
                        $display("id=%0d new=%0b cnt=%0d ovf=%0b fin=%0b",
                                 got.id, got.is_new, got.count, got.overflow,
                                 got.final_res);
                    end
                end else begin
                    want = expected_ids.pop_front();
                    if (got.id !== want.id || got.is_new !== want.is_new ||
                        got.count !== want.count || got.overflow !== want.overflow ||
                        got.final_res !== want.final_res) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $write("%0t: mismatch exp id=%0d new=%0b cnt=%0d ovf=%0b fin=%0b, ",
                                   $realtime, want.id, want.is_new, want.count,
                                   want.overflow, want.final_res);
                            $display("got id=%0d new=%0b cnt=%0d ovf=%0b fin=%0b",
                                     got.id, got.is_new, got.count, got.overflow,
                                     got.final_res);
                        end
                    end
                end
            end
        end
        o_mismatches  <= mismatch_cnt;
        o_outstanding <= expected_ids.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tdia_pkg::*;

    localparam int MAX_POSITIONS = 128;
    // One word can scan the whole table; the margin also covers overhead.
    localparam int DRAIN_CYCLES  = MAX_POSITIONS + 16;
    localparam int ITEMS_PER_PHASE = 200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               start_seq = 1'b0;
    logic               last_pos = 1'b0;
    logic [TRACK_W-1:0] voice0 = '0;
    logic [TRACK_W-1:0] voice1 = '0;
    logic [TRACK_W-1:0] voice2 = '0;
    logic [TRACK_W-1:0] voice3 = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [ID_W-1:0]    pattern_number;
    logic               is_new;
    logic [COUNT_W-1:0] pattern_count;
    logic               overflow;
    logic               final_result;

    int mismatches;
    int outstanding;
    int send_idle = 0;
    int recv_idle = 0;
    int words_sent = 0;

    // Tuples that a sequence reuses, so that repeats and matches are common.
    logic [TUPLE_W-1:0] tuple_pool [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tuple_dedup_id_assigner_top #(
        .MAX_POSITIONS(MAX_POSITIONS)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_start_sequence (start_seq),
        .i_last_position  (last_pos),
        .i_track_voice0   (voice0),
        .i_track_voice1   (voice1),
        .i_track_voice2   (voice2),
        .i_track_voice3   (voice3),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_pattern_number (pattern_number),
        .o_is_new         (is_new),
        .o_pattern_count  (pattern_count),
        .o_overflow       (overflow),
        .o_final_result   (final_result)
    );

    tdia_checker #(
        .MAX_POSITIONS(MAX_POSITIONS)
    ) checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_start_sequence (start_seq),
        .i_last_position  (last_pos),
        .i_track_voice0   (voice0),
        .i_track_voice1   (voice1),
        .i_track_voice2   (voice2),
        .i_track_voice3   (voice3),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_pattern_number (pattern_number),
        .i_is_new         (is_new),
        .i_pattern_count  (pattern_count),
        .i_overflow       (overflow),
        .i_final_result   (final_result),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    // The receiver stalls at random each cycle, at the rate of the current phase.
    always @(posedge clk) begin
        out_stall <= rst_n ? ($urandom_range(99) < recv_idle) : 1'b0;
    end

    // Offers one word and holds it until the block takes it. Random idle
    // cycles come first, so gaps land at every point of the scan.
    task automatic send_position(
        input logic               start,
        input logic               last,
        input logic [TUPLE_W-1:0] tuple
    );
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        start_seq <= start;
        last_pos  <= last;
        voice0    <= tuple[31:24];
        voice1    <= tuple[23:16];
        voice2    <= tuple[15:8];
        voice3    <= tuple[7:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // Holds the input side idle until every expected result word has come.
    // The first edge lets the checker count the word just accepted.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // One sequence: a start flag (usually), positions drawn from a small pool
    // with fresh tuples at fresh_pct percent and some near misses, and a last
    // flag. A little noise puts stray start and last flags in the middle.
    task automatic run_sequence(input int len, input int fresh_pct, input bit with_start);
        logic [TUPLE_W-1:0] tuple;
        int                 pool_len;
        bit                 start;
        bit                 last;
        pool_len = $urandom_range(1, 12);
        tuple_pool.delete();
        for (int i = 0; i < pool_len; i++) tuple_pool.push_back($urandom);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(99) < fresh_pct) begin
                tuple = $urandom;
            end else begin
                tuple = tuple_pool[$urandom_range(pool_len - 1)];
                // Near miss: one voice differs from a pooled tuple.
                if ($urandom_range(9) == 0)
                    tuple[$urandom_range(3) * 8 +: 8] = 8'($urandom);
            end
            start = (n == 0) ? with_start : ($urandom_range(99) < 2);
            last  = (n == len - 1) ? 1'b1 : ($urandom_range(99) < 3);
            send_position(start, last, tuple);
            if ($urandom_range(59) == 0) pause_until_drained();
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 22;
        recv_idle = 65;

        // Directed words: extreme tuples, exact repeats, one-voice near
        // misses, accumulation without a start flag, and back-to-back starts.
        send_position(1'b1, 1'b0, 32'h0000_0000);
        send_position(1'b0, 1'b0, 32'hFFFF_FFFF);
        send_position(1'b0, 1'b0, 32'h0000_0000);
        send_position(1'b0, 1'b0, 32'hAA55_AA55);
        send_position(1'b0, 1'b0, 32'h55AA_55AA);
        send_position(1'b0, 1'b0, 32'hFF00_0000);
        send_position(1'b0, 1'b0, 32'h00FF_0000);
        send_position(1'b0, 1'b0, 32'h0000_FF00);
        send_position(1'b0, 1'b0, 32'h0000_00FF);
        send_position(1'b0, 1'b1, 32'hFFFF_FFFF);
        send_position(1'b0, 1'b0, 32'h0000_0000);
        send_position(1'b0, 1'b1, 32'h0102_0304);
        send_position(1'b1, 1'b0, 32'hFFFF_FFFF);
        send_position(1'b1, 1'b0, 32'hFFFF_FFFF);
        send_position(1'b0, 1'b0, 32'hFFFF_FFFE);
        send_position(1'b0, 1'b0, 32'h7FFF_FFFF);
        send_position(1'b1, 1'b1, 32'h1234_5678);

        // Three idling phases. Each opens with one sequence long enough to
        // fill the table; the first uses only fresh tuples so the distinct
        // count reaches its top and the overflowing words match nothing.
        for (int phase = 0; phase < 3; phase++) begin
            pause_until_drained();
            case (phase)
                0: begin
                    send_idle = 22;
                    recv_idle = 65;
                end
                1: begin
                    send_idle = 65;
                    recv_idle = 22;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            run_sequence($urandom_range(MAX_POSITIONS + 1, MAX_POSITIONS + 12),
                         (phase == 0) ? 100 : 20, 1'b1);
            while (words_sent < ITEMS_PER_PHASE * (phase + 1))
                run_sequence($urandom_range(1, 24), 15, $urandom_range(9) != 0);
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Far above the slowest correct run, even if every word scans a full table.
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
